/* rtl/flr_pkg.sv */
// ----------------------------------------------------------------------------
// flr_pkg
// shared types and codes for the frame list keyed removal unit
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int FrameW    = 6;
  localparam int CountOutW = 7;

  localparam logic OpAppend = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  // scan engine status seen by the top level
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [FrameW-1:0] frame;
  } scan_stat_t;

endpackage

/* rtl/flr_ram.sv */
// ----------------------------------------------------------------------------
// flr_ram
// generic single write, single read port ram with registered read data
// ----------------------------------------------------------------------------
module flr_ram #(
  parameter int Width = 6,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/flr_scan.sv */
// ----------------------------------------------------------------------------
// flr_scan
// sequential search and compaction engine, one list entry per cycle
// ----------------------------------------------------------------------------
module flr_scan #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [flr_pkg::FrameW-1:0]        key_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   len_i,
  input  logic                              ack_i,
  output flr_pkg::scan_stat_t               stat_o,
  output logic [$clog2(LIST_DEPTH)-1:0]     ram_raddr_o,
  input  logic [flr_pkg::FrameW-1:0]        ram_rdata_i,
  output logic                              ram_we_o,
  output logic [$clog2(LIST_DEPTH)-1:0]     ram_waddr_o,
  output logic [flr_pkg::FrameW-1:0]        ram_wdata_o
);

  localparam int AddrW = $clog2(LIST_DEPTH);
  localparam int CntW  = $clog2(LIST_DEPTH + 1);

  typedef enum logic {
    SIdle,
    SScan
  } state_e;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            ptr_q, ptr_d;
  logic                       rv_q, rv_d;
  logic [AddrW-1:0]           ridx_q, ridx_d;
  logic                       found_q, found_d;
  logic [flr_pkg::FrameW-1:0] frame_q, frame_d;
  logic [flr_pkg::FrameW-1:0] key_q, key_d;

  logic issue;
  logic drained;
  logic hit;

  assign issue   = (state_q == SScan) && (ptr_q < len_i);
  assign drained = (state_q == SScan) && !rv_q && !issue;
  // the one shared compare
  assign hit     = rv_q && !found_q && (ram_rdata_i == key_q);

  assign ram_raddr_o = ptr_q[AddrW-1:0];
  // after the match every later entry moves down by one
  assign ram_we_o    = (state_q == SScan) && rv_q && found_q;
  assign ram_waddr_o = ridx_q - AddrW'(1);
  assign ram_wdata_o = ram_rdata_i;

  assign stat_o.busy  = (state_q != SIdle);
  assign stat_o.done  = drained;
  assign stat_o.found = found_q;
  assign stat_o.frame = frame_q;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    rv_d    = rv_q;
    ridx_d  = ridx_q;
    found_d = found_q;
    frame_d = frame_q;
    key_d   = key_q;
    case (state_q)
      SIdle: begin
        rv_d = 1'b0;
        if (start_i) begin
          state_d = SScan;
          ptr_d   = '0;
          found_d = 1'b0;
          frame_d = '0;
          key_d   = key_i;
        end
      end
      SScan: begin
        rv_d   = issue;
        ridx_d = ptr_q[AddrW-1:0];
        if (issue) begin
          ptr_d = ptr_q + CntW'(1);
        end
        if (hit) begin
          found_d = 1'b1;
          frame_d = ram_rdata_i;
        end
        if (drained && ack_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rv_q    <= rv_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= ridx_d;
    frame_q <= frame_d;
    key_q   <= key_d;
  end

endmodule

/* rtl/frame_list_keyed_removal_unit.sv */
// ----------------------------------------------------------------------------
// frame_list_keyed_removal_unit
// ordered frame number list with append at tail and removal of the first
// entry matching a key, order of the rest kept
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | op_i, frame_number_i
//  out     | output    | out_valid_o/out_stall_i | status_o, removed_frame_o,
//          |           |                      | entry_count_o
//
// an append, a full list or a removal on an empty list finishes in the cycle
// of the request; a removal runs a search and compaction pass through the
// single ram read port, one entry per cycle, before its result is registered.
// reset empties the list; the ram contents are not cleared.
// a request is taken while a result waits, as long as the output register
// can be freed; a finishing removal waits for a stalled result to leave.
module frame_list_keyed_removal_unit #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [flr_pkg::FrameW-1:0]    frame_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [flr_pkg::FrameW-1:0]    removed_frame_o,
  output logic [flr_pkg::CountOutW-1:0] entry_count_o
);

  localparam int AddrW = $clog2(LIST_DEPTH);
  localparam int CntW  = $clog2(LIST_DEPTH + 1);

  logic [CntW-1:0]                len_q, len_d;
  logic                           out_valid_q, out_valid_d;
  flr_pkg::status_e               out_status_q, out_status_d;
  logic [flr_pkg::FrameW-1:0]     out_frame_q, out_frame_d;
  logic [flr_pkg::CountOutW-1:0]  out_count_q, out_count_d;

  flr_pkg::scan_stat_t            scan_stat;
  logic                           in_acc;
  logic                           out_free;
  logic                           is_full;
  logic                           app_we;
  logic                           scan_start;
  logic                           scan_fin;
  logic [CntW-1:0]                len_new;

  logic [AddrW-1:0]               ram_raddr;
  logic [flr_pkg::FrameW-1:0]     ram_rdata;
  logic                           seq_we;
  logic [AddrW-1:0]               seq_waddr;
  logic [flr_pkg::FrameW-1:0]     seq_wdata;
  logic                           ram_we;
  logic [AddrW-1:0]               ram_waddr;
  logic [flr_pkg::FrameW-1:0]     ram_wdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = scan_stat.busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_full    = (len_q == CntW'(LIST_DEPTH));
  assign app_we     = in_acc && (op_i == flr_pkg::OpAppend) && !is_full;
  assign scan_start = in_acc && (op_i == flr_pkg::OpRemove) && (len_q != '0);
  assign scan_fin   = scan_stat.done && out_free;

  // append writes only while the scan engine is idle
  assign ram_we    = app_we || seq_we;
  assign ram_waddr = app_we ? len_q[AddrW-1:0] : seq_waddr;
  assign ram_wdata = app_we ? frame_number_i : seq_wdata;

  flr_ram #(
    .Width (flr_pkg::FrameW),
    .Depth (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  flr_scan #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .key_i       (frame_number_i),
    .len_i       (len_q),
    .ack_i       (out_free),
    .stat_o      (scan_stat),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (seq_we),
    .ram_waddr_o (seq_waddr),
    .ram_wdata_o (seq_wdata)
  );

  always_comb begin
    len_d        = len_q;
    len_new      = len_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    out_count_d  = out_count_q;
    if (in_acc && !scan_start) begin
      out_valid_d = 1'b1;
      out_frame_d = '0;
      if (op_i == flr_pkg::OpAppend) begin
        if (is_full) begin
          out_status_d = flr_pkg::StFull;
        end else begin
          out_status_d = flr_pkg::StOk;
          len_new      = len_q + CntW'(1);
        end
      end else begin
        out_status_d = flr_pkg::StEmpty;
      end
      len_d       = len_new;
      out_count_d = flr_pkg::CountOutW'(len_new);
    end else if (scan_fin) begin
      out_valid_d = 1'b1;
      if (scan_stat.found) begin
        out_status_d = flr_pkg::StOk;
        out_frame_d  = scan_stat.frame;
        len_new      = len_q - CntW'(1);
      end else begin
        out_status_d = flr_pkg::StNotFound;
        out_frame_d  = '0;
      end
      len_d       = len_new;
      out_count_d = flr_pkg::CountOutW'(len_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_frame_o = out_frame_q;
  assign entry_count_o   = out_count_q;

  // list length stays within the ram
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CntW'(LIST_DEPTH))
    else $error("list length beyond depth");

  // append and compaction never share the write port
  a_wr_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(app_we && seq_we))
    else $error("append write during compaction");

  // a successful removal shortens the list by one
  a_rm_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fin && scan_stat.found |=> len_q == $past(len_q) - CntW'(1))
    else $error("removal did not shorten list");

  // a finished scan always hands over a result
  a_fin_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fin |=> out_valid_q && !scan_stat.busy)
    else $error("finished scan lost its result");

endmodule

/* test/frame_list_keyed_removal_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_list_keyed_removal_unit_tb
// drives append and keyed removal requests into the frame list unit and
// checks every result against an in-bench list model, with random gaps on
// the request side, random and long stalls on the result side
// ----------------------------------------------------------------------------
module frame_list_keyed_removal_unit_tb;

  localparam int LIST_DEPTH     = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    flr_pkg::status_e                status;
    logic [flr_pkg::FrameW-1:0]      removed;
    logic [flr_pkg::CountOutW-1:0]   count;
  } list_outcome_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          op_i           = flr_pkg::OpAppend;
  logic [flr_pkg::FrameW-1:0]    frame_number_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic [1:0]                    status_o;
  logic [flr_pkg::FrameW-1:0]    removed_frame_o;
  logic [flr_pkg::CountOutW-1:0] entry_count_o;

  // list model
  logic [flr_pkg::FrameW-1:0] list_frames [LIST_DEPTH];
  int                         list_len = 0;

  list_outcome_t pending_outcomes [$];
  int requests_sent  = 0;
  int requests_taken = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  int src_idle_pct   = 30;
  int sink_stall_pct = 30;
  int holds_asked    = 0;
  int holds_given    = 0;
  int hold_left      = 0;

  frame_list_keyed_removal_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_frame_o(removed_frame_o),
    .entry_count_o  (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic list_outcome_t apply_list_op(logic op,
                                                  logic [flr_pkg::FrameW-1:0] key);
    list_outcome_t res;
    int pos;
    res.status  = flr_pkg::StOk;
    res.removed = '0;
    if (op == flr_pkg::OpAppend) begin
      if (list_len >= LIST_DEPTH) begin
        res.status = flr_pkg::StFull;
      end else begin
        list_frames[list_len] = key;
        list_len++;
      end
    end else if (list_len == 0) begin
      res.status = flr_pkg::StEmpty;
    end else begin
      pos = 0;
      while (pos < list_len && list_frames[pos] !== key) pos++;
      if (pos >= list_len) begin
        res.status = flr_pkg::StNotFound;
      end else begin
        res.removed = list_frames[pos];
        for (int k = pos; k < list_len - 1; k++) list_frames[k] = list_frames[k + 1];
        list_len--;
      end
    end
    res.count = flr_pkg::CountOutW'(list_len);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // input side feeds the model first, so a same-edge result still finds its entry
  always @(posedge clk_i) begin
    list_outcome_t exp_res;
    logic in_take;
    logic out_take;
    in_take  = rst_ni && in_valid_i && in_stall_o === 1'b0;
    out_take = rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0;
    if (in_take) begin
      pending_outcomes.push_back(apply_list_op(op_i, frame_number_i));
      requests_taken++;
    end
    if (out_take) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d removed %0d count %0d",
                                status_o, removed_frame_o, entry_count_o));
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (status_o !== exp_res.status || removed_frame_o !== exp_res.removed ||
            entry_count_o !== exp_res.count) begin
          note_mismatch($sformatf(
            "result mismatch: expected status %0d removed %0d count %0d, got %0d %0d %0d",
            exp_res.status, exp_res.removed, exp_res.count,
            status_o, removed_frame_o, entry_count_o));
        end
      end
    end
    if (in_take || out_take) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("frame_list_keyed_removal_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // result side stall, with an occasional long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_asked != holds_given) begin
      holds_given <= holds_given + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_request(input logic op, input logic [flr_pkg::FrameW-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    frame_number_i <= key;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    requests_sent++;
    // let the monitor update the model before the next request is chosen
    wait (requests_taken == requests_sent);
  endtask

  task automatic test_empty_removal();
    send_request(flr_pkg::OpRemove, 6'd0);
    send_request(flr_pkg::OpRemove, 6'd63);
  endtask

  task automatic test_order_and_duplicates();
    send_request(flr_pkg::OpAppend, 6'd0);
    send_request(flr_pkg::OpAppend, 6'd63);
    send_request(flr_pkg::OpAppend, 6'd21);
    send_request(flr_pkg::OpAppend, 6'd42);
    send_request(flr_pkg::OpAppend, 6'd63);
    send_request(flr_pkg::OpRemove, 6'd63);   // first of two copies goes
    send_request(flr_pkg::OpRemove, 6'd7);
    send_request(flr_pkg::OpRemove, 6'd63);   // match in the last slot
    send_request(flr_pkg::OpRemove, 6'd0);
    send_request(flr_pkg::OpRemove, 6'd42);
    send_request(flr_pkg::OpRemove, 6'd21);
    send_request(flr_pkg::OpRemove, 6'd21);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH)
      send_request(flr_pkg::OpAppend, flr_pkg::FrameW'($urandom_range(63)));
    send_request(flr_pkg::OpAppend, 6'd0);
    send_request(flr_pkg::OpAppend, 6'd63);
    send_request(flr_pkg::OpRemove, list_frames[LIST_DEPTH-1]);
    send_request(flr_pkg::OpAppend, 6'd42);
    send_request(flr_pkg::OpAppend, 6'd21);
    while (list_len > 0) begin
      if ($urandom_range(9) == 0)
        send_request(flr_pkg::OpRemove, flr_pkg::FrameW'($urandom_range(63)));
      else send_request(flr_pkg::OpRemove, list_frames[$urandom_range(list_len - 1)]);
    end
  endtask

  task automatic test_backpressure();
    int saved_idle;
    saved_idle   = src_idle_pct;
    src_idle_pct = 0;
    holds_asked++;
    repeat (30) begin
      if ($urandom_range(3) == 0 && list_len > 0)
        send_request(flr_pkg::OpRemove, list_frames[$urandom_range(list_len - 1)]);
      else
        send_request(flr_pkg::OpAppend, flr_pkg::FrameW'($urandom_range(63)));
    end
    src_idle_pct = saved_idle;
  endtask

  task automatic test_random_mix(input int n_items);
    int i;
    int append_bias;
    logic op;
    logic [flr_pkg::FrameW-1:0] key;
    append_bias = 50;
    for (i = 0; i < n_items; i++) begin
      // drifting bias lets the length wander from empty to full
      if (i % 40 == 0) append_bias = $urandom_range(25, 80);
      op = ($urandom_range(99) < append_bias) ? flr_pkg::OpAppend : flr_pkg::OpRemove;
      if (op == flr_pkg::OpAppend)
        key = ($urandom_range(3) == 0) ? flr_pkg::FrameW'($urandom_range(3))
                                       : flr_pkg::FrameW'($urandom_range(63));
      else if (list_len > 0 && $urandom_range(9) < 7)
        key = list_frames[$urandom_range(list_len - 1)];
      else
        key = flr_pkg::FrameW'($urandom_range(63));
      send_request(op, key);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_removal();
    test_order_and_duplicates();
    test_full_list();
    test_backpressure();
    test_random_mix(360);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_mix(100);
    src_idle_pct   = 30;
    sink_stall_pct = 30;

    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("frame_list_keyed_removal_unit_tb: done, clean");
    end else begin
      $display("frame_list_keyed_removal_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* frame_list_keyed_removal_unit.f */
rtl/flr_pkg.sv
rtl/flr_ram.sv
rtl/flr_scan.sv
rtl/frame_list_keyed_removal_unit.sv
test/frame_list_keyed_removal_unit_tb.sv
